/* rtl/bbmne_pkg.sv */
// Package: shared constants, types and the control store of the note encoder.
`default_nettype none

package bbmne_pkg;

  // Default number of scanned buttons
  localparam int unsigned BUTTON_COUNT_DEF = 32;

  // Message constants
  localparam logic [7:0]  NOTE_STATUS    = 8'h90;
  localparam logic [6:0]  VEL_ON         = 7'd127;
  localparam logic [6:0]  VEL_OFF        = 7'd0;
  localparam logic [15:0] INTERVAL_RESET = 16'd1000;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RESEND_EN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 1'b1;

  // Stream payload widths
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 32;

  // Step counter and its program addresses
  typedef logic [1:0] step_t;
  localparam step_t STEP_WAIT   = 2'd0;
  localparam step_t STEP_RESEND = 2'd1;
  localparam step_t STEP_SCAN   = 2'd2;

  // Datapath operation selected by a control word
  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_ACCEPT = 2'd1,
    OP_RESEND = 2'd2,
    OP_SCAN   = 2'd3
  } op_e;

  // Jump condition of a control word
  typedef enum logic [1:0] {
    COND_NEVER     = 2'd0,
    COND_ACCEPT    = 2'd1,
    COND_SCAN_DONE = 2'd2
  } cond_e;

  // One control word: take jump_to when the condition holds, else next_to
  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t jump_to;
    step_t next_to;
  } ucode_t;

  // One note message
  typedef struct packed {
    logic [7:0] status;
    logic [6:0] note;
    logic [6:0] vel;
  } msg_t;

  // Control store
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      STEP_WAIT:   w = '{op: OP_ACCEPT, cond: COND_ACCEPT,
                         jump_to: STEP_RESEND, next_to: STEP_WAIT};
      STEP_RESEND: w = '{op: OP_RESEND, cond: COND_NEVER,
                         jump_to: STEP_WAIT, next_to: STEP_SCAN};
      STEP_SCAN:   w = '{op: OP_SCAN, cond: COND_SCAN_DONE,
                         jump_to: STEP_WAIT, next_to: STEP_SCAN};
      default:     w = '{op: OP_NOP, cond: COND_NEVER,
                         jump_to: STEP_WAIT, next_to: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/button_bank_midi_note_encoder_core.sv */
// Top level: scan-tick to note-message encoder run by a small control store.
`default_nettype none

// Each accepted scan tick updates the bank from falling edges of the two
// bank buttons, then a three-step program runs: accept, resend check, and a
// scan step that visits one button index per cycle unless the output side
// stalls, emitting a note message for each changed button into a one-item
// output register. The scan ends at the highest changed button index, or at
// index 0 when nothing changed. The input is not ready again until the last
// message of the tick is in the output register, which then drains while
// the next tick is taken.
module button_bank_midi_note_encoder_core #(
  parameter int unsigned BUTTON_COUNT = bbmne_pkg::BUTTON_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [bbmne_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bbmne_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // scan tick input
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] pressed_buttons, [32] bank_up_level, [33] bank_down_level
  input  logic [bbmne_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // note message output
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] status_byte, [14:8] note_number, [21:15] velocity,
  // [27:22] current_bank_out
  output logic [bbmne_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // [0] is_repeat
  output logic [0:0]                       m_axis_tuser,
  output logic                             m_axis_tlast
);
  import bbmne_pkg::*;

  localparam int unsigned IDX_W = $clog2(BUTTON_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUTTON_COUNT - 1);
  localparam logic [BUTTON_COUNT-1:0] ONE_HOT0 = BUTTON_COUNT'(1);

  // configuration
  logic        resend_en_q;
  logic [15:0] interval_q;

  // sequencer and datapath state
  step_t                   step_q, step_d;
  logic [5:0]              bank_q, bank_d;
  logic [BUTTON_COUNT-1:0] prev_q, prev_d;
  logic [BUTTON_COUNT-1:0] changed_q, changed_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  msg_t                    last_msg_q, last_msg_d;
  logic [16:0]             idle_q, idle_d;
  logic                    up_prev_q, up_prev_d;
  logic                    down_prev_q, down_prev_d;

  // output register
  logic       m_valid_q;
  msg_t       m_msg_q;
  logic       m_rep_q;
  logic       m_last_q;
  logic [5:0] m_bank_q;

  // datapath control
  ucode_t                  uc;
  logic                    accepted;
  logic                    slot_free;
  logic                    emit, stall, cond_hit;
  logic                    scan_done;
  msg_t                    emit_msg;
  logic                    emit_rep, emit_last;
  logic [16:0]             idle_inc;
  logic                    fire;
  logic [BUTTON_COUNT-1:0] changed_clr;
  msg_t                    note_msg;
  logic [5:0]              bank_up;
  logic                    up_lvl, down_lvl;

  assign uc            = ucode_rom(step_q);
  assign s_axis_tready = (uc.op == OP_ACCEPT);
  assign accepted      = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !m_valid_q || m_axis_tready;

  assign up_lvl   = s_axis_tdata[BUTTON_COUNT_DEF];
  assign down_lvl = s_axis_tdata[BUTTON_COUNT_DEF + 1];
  assign bank_up  = (!up_lvl && up_prev_q) ? bank_q + 6'd1 : bank_q;

  assign idle_inc    = idle_q + 17'd1;
  assign fire        = idle_inc > {1'b0, interval_q};
  assign changed_clr = changed_q & ~(ONE_HOT0 << idx_q);
  assign scan_done   = (~|changed_clr) || (idx_q == IDX_LAST);

  // note message for the button under the scan index
  assign note_msg.status = NOTE_STATUS | {4'b0000, bank_q[5:2]};
  assign note_msg.note   = {bank_q[1:0], 5'b00000} + 7'(idx_q);
  assign note_msg.vel    = prev_q[idx_q] ? VEL_ON : VEL_OFF;

  // execute the current control word
  always_comb begin
    bank_d      = bank_q;
    prev_d      = prev_q;
    changed_d   = changed_q;
    idx_d       = idx_q;
    last_msg_d  = last_msg_q;
    idle_d      = idle_q;
    up_prev_d   = up_prev_q;
    down_prev_d = down_prev_q;
    emit        = 1'b0;
    emit_msg    = last_msg_q;
    emit_rep    = 1'b0;
    emit_last   = 1'b0;
    stall       = 1'b0;
    case (uc.op)
      OP_ACCEPT: begin
        if (accepted) begin
          // step the bank: up first, then down
          bank_d      = (!down_lvl && down_prev_q) ? bank_up - 6'd1 : bank_up;
          up_prev_d   = up_lvl;
          down_prev_d = down_lvl;
          changed_d   = s_axis_tdata[BUTTON_COUNT-1:0] ^ prev_q;
          prev_d      = s_axis_tdata[BUTTON_COUNT-1:0];
          idx_d       = '0;
        end
      end
      OP_RESEND: begin
        if (resend_en_q) begin
          if (fire) begin
            emit      = 1'b1;
            emit_msg  = last_msg_q;
            emit_rep  = 1'b1;
            emit_last = ~|changed_q;
            if (slot_free) begin
              idle_d = '0;
            end else begin
              stall = 1'b1;
            end
          end else begin
            idle_d = idle_inc;
          end
        end
      end
      OP_SCAN: begin
        if (changed_q[idx_q]) begin
          emit      = 1'b1;
          emit_msg  = note_msg;
          emit_last = ~|changed_clr;
          if (slot_free) begin
            changed_d  = changed_clr;
            last_msg_d = note_msg;
            idle_d     = '0;
          end else begin
            stall = 1'b1;
          end
        end
        if (!stall) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      default: ;
    endcase
    // evaluate the jump condition of the control word
    case (uc.cond)
      COND_ACCEPT:    cond_hit = accepted;
      COND_SCAN_DONE: cond_hit = scan_done;
      default:        cond_hit = 1'b0;
    endcase
    // hold on stall, else take the jump or fall to the next step
    if (stall) begin
      step_d = step_q;
    end else if (cond_hit) begin
      step_d = uc.jump_to;
    end else begin
      step_d = uc.next_to;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resend_en_q <= 1'b0;
      interval_q  <= INTERVAL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RESEND_EN: resend_en_q <= cfg_data_i[0];
        CFG_INTERVAL:  interval_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_WAIT;
      bank_q      <= '0;
      prev_q      <= '0;
      changed_q   <= '0;
      idx_q       <= '0;
      last_msg_q  <= '0;
      idle_q      <= '0;
      up_prev_q   <= 1'b1;
      down_prev_q <= 1'b1;
    end else begin
      step_q      <= step_d;
      bank_q      <= bank_d;
      prev_q      <= prev_d;
      changed_q   <= changed_d;
      idx_q       <= idx_d;
      last_msg_q  <= last_msg_d;
      idle_q      <= idle_d;
      up_prev_q   <= up_prev_d;
      down_prev_q <= down_prev_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit && !stall) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (emit && !stall) begin
      m_msg_q  <= emit_msg;
      m_rep_q  <= emit_rep;
      m_last_q <= emit_last;
      m_bank_q <= bank_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, m_bank_q, m_msg_q.vel, m_msg_q.note, m_msg_q.status};
  assign m_axis_tuser  = m_rep_q;
  assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

/* rtl/bbmne_checker.sv */
// Checker: port-level properties of the note encoder, bound to the top level.
`default_nettype none

module bbmne_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled output item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled output item changed");

  // an accepted tick keeps the input closed for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input reopened right after a tick");

  // no new tick while a tick still has messages to come
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready in the middle of a tick");

  // velocity is either on or off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[21:15] == 7'd0) || (m_axis_tdata[21:15] == 7'd127))
    else $error("velocity out of range");

  // fresh notes carry a note-on status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:4] == 4'h9)
    else $error("note item without note-on status");

endmodule

bind button_bank_midi_note_encoder_core bbmne_checker u_bbmne_checker (.*);

`default_nettype wire

/* tb/sv/bbmne_note_tracker.sv */
// Note encoder tracker: predicts note messages from accepted scan ticks and checks the output.
`default_nettype none

module bbmne_note_tracker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bbmne_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bbmne_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  // [31:0] pressed_buttons, [32] bank_up_level, [33] bank_down_level
  input  logic [bbmne_pkg::S_TDATA_W-1:0]  s_tdata_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  // [7:0] status_byte, [14:8] note_number, [21:15] velocity, [27:22] current_bank_out
  input  logic [bbmne_pkg::M_TDATA_W-1:0]  m_tdata_i,
  // [0] is_repeat
  input  logic [0:0]                       m_tuser_i,
  input  logic                             m_tlast_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               msg_count_o,
  output int                               resend_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bbmne_pkg::*;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] note;
    logic [6:0] vel;
    logic       is_rep;
    logic [5:0] bank;
    logic       last;
  } note_out_t;

  // Shadow registers and encoder state
  logic        resend_en;
  logic [15:0] interval;
  logic [5:0]  bank;
  logic [31:0] prev_pressed;
  msg_t        last_msg;
  logic [16:0] idle_ticks;
  logic        up_prev;
  logic        down_prev;

  note_out_t   expected_notes[$];
  note_out_t   held_note;
  logic        held_valid;

  // Hold one message back so the final one of a tick can be marked
  task automatic queue_note(input msg_t m, input logic rep);
    if (held_valid) expected_notes.push_back(held_note);
    held_note.status = m.status;
    held_note.note   = m.note;
    held_note.vel    = m.vel;
    held_note.is_rep = rep;
    held_note.bank   = bank;
    held_note.last   = 1'b0;
    held_valid       = 1'b1;
  endtask

  // Work out every note message one scan tick causes
  task automatic encode_tick(input logic [31:0] pressed, input logic up, input logic down);
    logic [31:0] changed;
    logic [7:0]  status;
    msg_t        m;
    // bank edges, up first so that both together cancel
    if (!up && up_prev) bank = bank + 6'd1;
    if (!down && down_prev) bank = bank - 6'd1;
    up_prev   = up;
    down_prev = down;

    if (resend_en) begin
      idle_ticks = idle_ticks + 17'd1;
      if (idle_ticks > {1'b0, interval}) begin
        queue_note(last_msg, 1'b1);
        idle_ticks = '0;
      end
    end

    changed = pressed ^ prev_pressed;
    status  = NOTE_STATUS | {4'd0, bank[5:2]};
    for (int i = 0; i < 32; i++) begin
      if (changed[i]) begin
        m.status = status;
        m.note   = i[6:0] + {bank[1:0], 5'd0};
        m.vel    = pressed[i] ? VEL_ON : VEL_OFF;
        queue_note(m, 1'b0);
        last_msg   = m;
        idle_ticks = '0;
      end
    end
    prev_pressed = pressed;

    if (held_valid) begin
      held_note.last = 1'b1;
      expected_notes.push_back(held_note);
      held_valid = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    note_out_t got;
    note_out_t want;
    if (!rst_ni) begin
      resend_en      = 1'b0;
      interval       = INTERVAL_RESET;
      bank           = '0;
      prev_pressed   = '0;
      last_msg       = '0;
      idle_ticks     = '0;
      up_prev        = 1'b1;
      down_prev      = 1'b1;
      held_valid     = 1'b0;
      expected_notes.delete();
      fail_count_o   = 0;
      msg_count_o    = 0;
      resend_count_o = 0;
    end else begin
      // track register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_RESEND_EN) resend_en = cfg_data_i[0];
        else if (cfg_idx_i == CFG_INTERVAL) interval = cfg_data_i[15:0];
      end

      // check an accepted note message against the oldest one expected
      if (m_tvalid_i && m_tready_i) begin
        got.status = m_tdata_i[7:0];
        got.note   = m_tdata_i[14:8];
        got.vel    = m_tdata_i[21:15];
        got.bank   = m_tdata_i[27:22];
        got.is_rep = m_tuser_i[0];
        got.last   = m_tlast_i;
        msg_count_o++;
        if (got.is_rep) resend_count_o++;
        if (expected_notes.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected note message st=%02h note=%0d vel=%0d rep=%0b bank=%0d last=%0b",
                   $time, got.status, got.note, got.vel, got.is_rep, got.bank, got.last);
        end else begin
          want = expected_notes.pop_front();
          if (got !== want) begin
            fail_count_o++;
            $display("%0t: note message mismatch: expected st=%02h note=%0d vel=%0d rep=%0b bank=%0d last=%0b",
                     $time, want.status, want.note, want.vel, want.is_rep, want.bank, want.last);
            $display("%0t:                         actual st=%02h note=%0d vel=%0d rep=%0b bank=%0d last=%0b",
                     $time, got.status, got.note, got.vel, got.is_rep, got.bank, got.last);
          end
        end
      end

      // predict the messages of an accepted scan tick
      if (s_tvalid_i && s_tready_i) encode_tick(s_tdata_i[31:0], s_tdata_i[32], s_tdata_i[33]);
    end
    pending_o = expected_notes.size();
  end

endmodule

`default_nettype wire

/* tb/sv/button_bank_midi_note_encoder_core_tb.sv */
// Testbench top: drives scan ticks and register writes into the note encoder and reports the verdict.
`default_nettype none

module button_bank_midi_note_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbmne_pkg::*;

  localparam int RANDOM_TICKS   = 150;   // per handshake mix
  localparam int REG_PERIOD     = 38;    // ticks between register changes
  localparam int DRAIN_CYCLES   = 40;    // a full scan plus margin
  localparam int WATCHDOG_LIMIT = 4000;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [S_TDATA_W-1:0]    s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [M_TDATA_W-1:0]    m_axis_tdata;
  logic [0:0]              m_axis_tuser;
  logic                    m_axis_tlast;

  int fail_count;
  int pending_notes;
  int msg_count;
  int resend_count;
  int snd_idle_pct;
  int rcv_idle_pct;
  int tick_count;
  int reg_settings;
  logic [31:0] cur_pressed;

  button_bank_midi_note_encoder_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  bbmne_note_tracker tracker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .m_tuser_i      (m_axis_tuser),
    .m_tlast_i      (m_axis_tlast),
    .fail_count_o   (fail_count),
    .pending_o      (pending_notes),
    .msg_count_o    (msg_count),
    .resend_count_o (resend_count)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stall the output side at the current rate
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // End the run when nothing moves for too long
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stuck = 0;
      else
        stuck++;
    end
    $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Offer one scan tick, idling first at the sender rate; entered and left at a falling edge
  task automatic send_tick(input logic [31:0] pressed, input logic up, input logic down);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W-34){1'b0}}, down, up, pressed};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    tick_count++;
  endtask

  // Hold off the sender until every expected message is out and the block is idle
  task automatic wait_for_notes_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_notes != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  // Pick a new register setting, mostly short intervals so resends occur
  task automatic set_random_registers();
    logic [15:0] ivl;
    case ($urandom_range(5))
      0:       ivl = 16'd0;
      1:       ivl = 16'hFFFF;
      default: ivl = 16'($urandom_range(12));
    endcase
    wait_for_notes_drained();
    write_reg(CFG_RESEND_EN, CFG_DATA_W'($urandom_range(3) != 0));
    write_reg(CFG_INTERVAL, ivl);
    reg_settings++;
  endtask

  // One random tick, or a run of unchanged ticks to let the idle counter climb
  task automatic send_random(inout int sent);
    int run;
    if ($urandom_range(9) == 0) begin
      run = $urandom_range(12, 2);
      repeat (run) send_tick(cur_pressed, $urandom_range(3) != 0, $urandom_range(3) != 0);
      sent += run;
    end else begin
      case ($urandom_range(9))
        0, 1:    ;
        2, 3, 4: cur_pressed[$urandom_range(31)] ^= 1'b1;
        5:       repeat ($urandom_range(3, 1)) cur_pressed[$urandom_range(31)] ^= 1'b1;
        6:       cur_pressed ^= $urandom & $urandom & $urandom;
        7:       cur_pressed = $urandom;
        8:       cur_pressed = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        default: cur_pressed[$urandom_range(3)] ^= 1'b1;
      endcase
      send_tick(cur_pressed, $urandom_range(3) != 0, $urandom_range(3) != 0);
      sent++;
    end
  endtask

  initial begin
    int sent;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    snd_idle_pct  = 0;
    rcv_idle_pct  = 20;
    tick_count    = 0;
    reg_settings  = 0;
    cur_pressed   = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // No change and resend off: no message
    send_tick(32'h0, 1'b1, 1'b1);
    // Resend before any note carries the all-zero message
    wait_for_notes_drained();
    write_reg(CFG_RESEND_EN, 16'd1);
    write_reg(CFG_INTERVAL, 16'd0);
    send_tick(32'h0, 1'b1, 1'b1);
    // Resend plus every button pressed: the longest tick
    send_tick(32'hFFFF_FFFF, 1'b1, 1'b1);
    wait_for_notes_drained();
    write_reg(CFG_RESEND_EN, 16'd0);
    send_tick(32'h0, 1'b1, 1'b1);
    // Bank down from zero wraps to the top bank
    send_tick(32'h0, 1'b1, 1'b0);
    send_tick(32'h8000_0001, 1'b1, 1'b1);
    // Bank up from the top wraps to zero
    send_tick(32'h8000_0001, 1'b0, 1'b1);
    send_tick(32'h8000_0001, 1'b1, 1'b1);
    // Both bank edges together leave the bank alone
    send_tick(32'h8000_0001, 1'b0, 1'b0);
    send_tick(32'h0000_0001, 1'b1, 1'b1);
    // Step through the four note ranges of one channel into the next
    send_tick(32'h1, 1'b0, 1'b1);
    send_tick(32'h3, 1'b1, 1'b1);
    send_tick(32'h2, 1'b0, 1'b1);
    send_tick(32'h2, 1'b1, 1'b1);
    send_tick(32'h6, 1'b0, 1'b1);
    send_tick(32'h6, 1'b1, 1'b1);
    send_tick(32'h7, 1'b0, 1'b1);
    // Let the idle counter climb, then lower the interval under it
    wait_for_notes_drained();
    write_reg(CFG_RESEND_EN, 16'd1);
    write_reg(CFG_INTERVAL, 16'd1000);
    repeat (4) send_tick(32'h7, 1'b1, 1'b1);
    wait_for_notes_drained();
    write_reg(CFG_INTERVAL, 16'd2);
    send_tick(32'h7, 1'b1, 1'b1);
    // Resend off holds the counter
    wait_for_notes_drained();
    write_reg(CFG_RESEND_EN, 16'd0);
    send_tick(32'h7, 1'b1, 1'b1);
    cur_pressed = 32'h7;

    // Random ticks under three handshake mixes
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 78 : 0;
      rcv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 32 : 0;
      sent = 0;
      while (sent < RANDOM_TICKS) begin
        if (sent % REG_PERIOD == 0) set_random_registers();
        send_random(sent);
      end
    end

    // Let everything drain, then give the verdict
    s_axis_tvalid <= 1'b0;
    while (pending_notes != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Ran %0d scan ticks giving %0d note messages, %0d of them resends,",
             tick_count, msg_count, resend_count);
    $display("over %0d random register settings and three stall mixes.", reg_settings);
    if (fail_count == 0 && pending_notes == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d messages never seen", fail_count, pending_notes);
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/bbmne_pkg.sv
rtl/button_bank_midi_note_encoder_core.sv
rtl/bbmne_checker.sv
tb/sv/bbmne_note_tracker.sv
tb/sv/button_bank_midi_note_encoder_core_tb.sv
